// ===== src/ppl_pkg.sv =====
// polyline path length: shared command and status types
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ppl_pkg;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // take the point word and its coordinate differences
    logic sq_x;       // square dx
    logic sq_y;       // square dy, start the sum
    logic sq_z;       // square dz (or zero in 2d), add dy^2
    logic load_root;  // load the radicand into the root unit
    logic root_step;  // one digit of the square root
    logic accum;      // add the segment length into the running total
    logic finish;     // update the previous point, emit and clear on the last point
  } ppl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic seg_needed; // incoming point closes a segment
    logic last;       // captured point is the last of its trajectory
    logic out_free;   // output register can take a new word this cycle
  } ppl_sts_t;

endpackage : ppl_pkg

`default_nettype wire

// ===== src/ppl_if.sv =====
// polyline path length: point and length channel interfaces
// valid/ready handshake with payload; no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ppl_in_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic                         point_missing;
  logic                         last_point;

  modport source (
    output valid, coord_x, coord_y, coord_z, point_missing, last_point,
    input  ready
  );
  modport sink (
    input  valid, coord_x, coord_y, coord_z, point_missing, last_point,
    output ready
  );
endinterface : ppl_in_if

interface ppl_out_if #(
  parameter int SUM_BITS = 40
);
  logic                valid;
  logic                ready;
  logic [SUM_BITS-1:0] path_length;
  logic                length_saturated;

  modport source (
    output valid, path_length, length_saturated,
    input  ready
  );
  modport sink (
    input  valid, path_length, length_saturated,
    output ready
  );
endinterface : ppl_out_if

`default_nettype wire

// ===== src/ppl_ctrl.sv =====
// polyline path length: sequencing state machine
// depends on ppl_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module ppl_ctrl #(
  parameter int COORD_BITS = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire ppl_pkg::ppl_sts_t sts_i,
  output      ppl_pkg::ppl_cmd_t cmd_o
);
  import ppl_pkg::*;

  localparam int CntW = $clog2(COORD_BITS + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQ_X   = 8'b0000_0010,
    S_SQ_Y   = 8'b0000_0100,
    S_SQ_Z   = 8'b0000_1000,
    S_LOAD   = 8'b0001_0000,
    S_ROOT   = 8'b0010_0000,
    S_ACCUM  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } ppl_state_e;

  ppl_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            root_last;

  assign root_last = (cnt_q == CntW'(COORD_BITS));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sts_i.seg_needed ? S_SQ_X : S_FINISH;
        end
      end
      S_SQ_X: begin
        cmd_o.sq_x = 1'b1;
        state_d    = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd_o.sq_y = 1'b1;
        state_d    = S_SQ_Z;
      end
      S_SQ_Z: begin
        cmd_o.sq_z = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load_root = 1'b1;
        cnt_d           = '0;
        state_d         = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q + CntW'(1);
        if (root_last) begin
          state_d = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        // a last point waits here while the previous length is still unread
        if (!sts_i.last || sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule : ppl_ctrl

`default_nettype wire

// ===== src/ppl_dp.sv =====
// polyline path length: datapath with shared squarer, bit-serial root,
// saturating accumulator and output register; depends on ppl_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppl_dp #(
  parameter int COORD_BITS = 24,
  parameter int SUM_BITS   = 40
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_wdata_i,
  input  wire logic signed [COORD_BITS-1:0] coord_x_i,
  input  wire logic signed [COORD_BITS-1:0] coord_y_i,
  input  wire logic signed [COORD_BITS-1:0] coord_z_i,
  input  wire logic                         point_missing_i,
  input  wire logic                         last_point_i,
  input  wire ppl_pkg::ppl_cmd_t            cmd_i,
  output      ppl_pkg::ppl_sts_t            sts_o,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic [SUM_BITS-1:0]          path_length_o,
  output      logic                         length_saturated_o
);
  import ppl_pkg::*;

  localparam int DiffW = COORD_BITS + 1;       // magnitude of a difference
  localparam int RadW  = 2 * COORD_BITS + 2;   // sum of up to three squares
  localparam int RootW = COORD_BITS + 1;
  localparam int RemW  = COORD_BITS + 3;
  localparam int AccW  = ((SUM_BITS > RootW) ? SUM_BITS : RootW) + 1;

  function automatic logic [DiffW-1:0] abs_diff(
    input logic [COORD_BITS-1:0] a,
    input logic [COORD_BITS-1:0] b
  );
    logic [DiffW-1:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return d[DiffW-1] ? (~d + DiffW'(1)) : d;
  endfunction

  logic                  three_dims_q;
  logic [COORD_BITS-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic                  prev_usable_q;
  logic [COORD_BITS-1:0] cur_x_q, cur_y_q, cur_z_q;
  logic                  cur_missing_q, cur_last_q;
  logic [DiffW-1:0]      dx_q, dy_q, dz_q;
  logic [RadW-1:0]       prod_q, acc_q, rad_q;
  logic [RootW-1:0]      root_q;
  logic [RemW-1:0]       rem_q;
  logic [SUM_BITS-1:0]   total_q;
  logic                  clamped_q;
  logic                  out_valid_q;
  logic [SUM_BITS-1:0]   out_len_q;
  logic                  out_sat_q;

  logic [DiffW-1:0] mul_op;
  logic [RadW-1:0]  mul_res;
  logic [RemW-1:0]  rem_sh, trial;
  logic             digit;
  logic [AccW-1:0]  sum_w;
  logic             over;

  // one shared squarer, operand picked per step
  always_comb begin
    mul_op = dz_q;
    if (cmd_i.sq_x) begin
      mul_op = dx_q;
    end else if (cmd_i.sq_y) begin
      mul_op = dy_q;
    end
  end
  assign mul_res = RadW'(mul_op) * RadW'(mul_op);

  // restoring square root, one result bit per step
  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign digit  = (rem_sh >= trial);

  assign sum_w = AccW'(total_q) + AccW'(root_q);
  assign over  = |sum_w[AccW-1:SUM_BITS];

  assign sts_o.seg_needed = !point_missing_i && prev_usable_q;
  assign sts_o.last       = cur_last_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign path_length_o      = out_len_q;
  assign length_saturated_o = out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_dims_q <= 1'b0;
    end else if (cfg_we_i) begin
      three_dims_q <= cfg_wdata_i;
    end
  end

  // point word and its differences to the stored point
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_x_q       <= coord_x_i;
      cur_y_q       <= coord_y_i;
      cur_z_q       <= coord_z_i;
      cur_missing_q <= point_missing_i;
      cur_last_q    <= last_point_i;
      dx_q          <= abs_diff(coord_x_i, prev_x_q);
      dy_q          <= abs_diff(coord_y_i, prev_y_q);
      dz_q          <= abs_diff(coord_z_i, prev_z_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_x || cmd_i.sq_y) begin
      prod_q <= mul_res;
    end else if (cmd_i.sq_z) begin
      prod_q <= three_dims_q ? mul_res : '0;
    end
    if (cmd_i.sq_y) begin
      acc_q <= prod_q;
    end else if (cmd_i.sq_z) begin
      acc_q <= acc_q + prod_q;
    end
    if (cmd_i.load_root) begin
      rad_q  <= acc_q + prod_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= digit ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[RootW-2:0], digit};
    end
  end

  // trajectory state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      prev_z_q      <= '0;
      prev_usable_q <= 1'b0;
      total_q       <= '0;
      clamped_q     <= 1'b0;
    end else if (cmd_i.accum) begin
      total_q   <= over ? '1 : sum_w[SUM_BITS-1:0];
      clamped_q <= clamped_q | over;
    end else if (cmd_i.finish) begin
      if (cur_last_q) begin
        prev_x_q      <= '0;
        prev_y_q      <= '0;
        prev_z_q      <= '0;
        prev_usable_q <= 1'b0;
        total_q       <= '0;
        clamped_q     <= 1'b0;
      end else begin
        if (!cur_missing_q) begin
          prev_x_q <= cur_x_q;
          prev_y_q <= cur_y_q;
          prev_z_q <= cur_z_q;
        end
        prev_usable_q <= !cur_missing_q;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish && cur_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && cur_last_q) begin
      out_len_q <= total_q;
      out_sat_q <= clamped_q;
    end
  end

endmodule : ppl_dp

`default_nettype wire

// ===== src/polyline_path_length_unit.sv =====
// polyline path length: top level joining controller and datapath
// depends on ppl_pkg, ppl_if, ppl_ctrl and ppl_dp
`timescale 1ns / 1ps
`default_nettype none

// Sums the Euclidean lengths of the segments of a trajectory that arrives one
// point word at a time, and delivers the total on the word marked last. A point
// that closes a segment is accepted, squares dx, dy and dz on the shared squarer,
// loads the root unit, runs the bit-serial square root one result bit per step,
// accumulates and finishes. A point that closes no segment (missing, first of a
// trajectory, or first after a gap) is only accepted and finished. The input is
// ready only between points; a last point holds in its finish step while the
// previous length word still waits in the output register. The total saturates
// at all ones and then sets length_saturated.
module polyline_path_length_unit #(
  parameter int COORD_BITS = 24,
  parameter int SUM_BITS   = 40
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,
  ppl_in_if.sink    pt_in,
  ppl_out_if.source len_out
);
  import ppl_pkg::*;

  ppl_cmd_t cmd;
  ppl_sts_t sts;

  ppl_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pt_in.valid),
    .in_ready_o (pt_in.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ppl_dp #(
    .COORD_BITS (COORD_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .coord_x_i          (pt_in.coord_x),
    .coord_y_i          (pt_in.coord_y),
    .coord_z_i          (pt_in.coord_z),
    .point_missing_i    (pt_in.point_missing),
    .last_point_i       (pt_in.last_point),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (len_out.valid),
    .out_ready_i        (len_out.ready),
    .path_length_o      (len_out.path_length),
    .length_saturated_o (len_out.length_saturated)
  );

endmodule : polyline_path_length_unit

`default_nettype wire

// ===== src/ppl_checker.sv =====
// polyline path length: port-level checks over time
// bound to polyline_path_length_unit; no other dependencies
`timescale 1ns / 1ps
`default_nettype none

module ppl_checker #(
  parameter int SUM_BITS = 40
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire logic [SUM_BITS-1:0] path_length_i,
  input wire logic                length_saturated_i
);

  // a word stalled at the output stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("length word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(path_length_i) && $stable(length_saturated_i))
    else $error("length word changed while stalled");

  // one point at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted point");

  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("length word appeared one cycle after a point");

  // a clamped total reads as all ones
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && length_saturated_i |-> (path_length_i == '1))
    else $error("saturated length is not the maximum");

endmodule : ppl_checker

bind polyline_path_length_unit ppl_checker #(
  .SUM_BITS (SUM_BITS)
) u_ppl_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (pt_in.valid),
  .in_ready_i         (pt_in.ready),
  .out_valid_i        (len_out.valid),
  .out_ready_i        (len_out.ready),
  .path_length_i      (len_out.path_length),
  .length_saturated_i (len_out.length_saturated)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for polyline_path_length_unit: directed table, a corner run, random phases
// depends on ppl_if (point and length channels) and the polyline_path_length_unit rtl
`timescale 1ns / 1ps

module testbench;

  localparam int COORD_W = 24;
  localparam int SUM_W = 40;
  localparam int SETTLE_CYCLES = 40;  // longer than one segment in the block
  localparam int TAIL_CYCLES = 64;
  localparam int LONG_HOLD = 800;
  localparam int CORNER_POINTS = 40;  // max 3d segments back and forth
  localparam int PHASES = 8;
  localparam int PHASE_POINTS = 236;
  localparam logic [SUM_W-1:0] LEN_MAX = '1;
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] COORD_TOP = {1'b0, {(COORD_W-1){1'b1}}};

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               missing;
    logic               last;
  } point_t;

  typedef struct packed {
    logic [SUM_W-1:0] length;
    logic             sat;
  } len_word_t;

  typedef enum logic {ROW_POINT, ROW_DIMS} row_kind_e;

  typedef struct {
    row_kind_e kind;
    point_t    pt;
    bit        dims;
    bit        typed;
    len_word_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic cfg_wdata;

  ppl_in_if #(.COORD_BITS(COORD_W)) pt_if ();
  ppl_out_if #(.SUM_BITS(SUM_W)) len_if ();

  polyline_path_length_unit #(
    .COORD_BITS(COORD_W),
    .SUM_BITS  (SUM_W)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .pt_in      (pt_if.sink),
    .len_out    (len_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // path state as the block should hold it
  logic [COORD_W-1:0] last_x, last_y, last_z;
  bit                 last_ok;
  logic [SUM_W-1:0]   path_sum;
  bit                 path_clamped;
  bit                 dims3;

  len_word_t pending_lengths[$];
  int mismatches = 0;
  int points_sent = 0;
  int lengths_checked = 0;
  int sat_seen = 0;
  int missing_sent = 0;
  int dims_writes = 0;
  int hold_asks = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  function automatic logic [COORD_W:0] abs_delta(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? -d : d;
  endfunction

  function automatic logic [63:0] square64(logic [COORD_W:0] a);
    logic [63:0] w;
    w = 64'(a);
    return w * w;
  endfunction

  // bit-pair restoring square root, truncates
  function automatic logic [31:0] root_floor(logic [63:0] v);
    logic [63:0] rem, trial;
    logic [31:0] root;
    int i;
    rem = '0;
    root = '0;
    for (i = 31; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 64'd3);
      trial = 64'({root, 2'b01});
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[30:0], 1'b1};
      end else begin
        root = {root[30:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic bit advance_path(input point_t p, output len_word_t r);
    logic [63:0] radicand;
    logic [SUM_W-1:0] seg;
    r = '0;
    if (!p.missing && last_ok) begin
      radicand = square64(abs_delta(p.x, last_x)) + square64(abs_delta(p.y, last_y));
      if (dims3) radicand = radicand + square64(abs_delta(p.z, last_z));
      seg = SUM_W'(root_floor(radicand));
      if (seg > LEN_MAX - path_sum) begin
        path_sum = LEN_MAX;
        path_clamped = 1'b1;
      end else begin
        path_sum = path_sum + seg;
      end
    end
    if (!p.missing) begin
      last_x = p.x;
      last_y = p.y;
      last_z = p.z;
    end
    last_ok = !p.missing;
    if (!p.last) return 1'b0;
    r.length = path_sum;
    r.sat = path_clamped;
    last_x = '0;
    last_y = '0;
    last_z = '0;
    last_ok = 1'b0;
    path_sum = '0;
    path_clamped = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // length word checker
  always @(posedge clk_i) begin
    len_word_t want;
    if (rst_ni && len_if.valid && len_if.ready) begin
      lengths_checked++;
      if (len_if.length_saturated) sat_seen++;
      if (pending_lengths.size() == 0) begin
        report_mismatch($sformatf("length word %0d with none expected", len_if.path_length));
      end else begin
        want = pending_lengths.pop_front();
        if (len_if.path_length !== want.length)
          report_mismatch($sformatf("path_length %0d, expected %0d",
                                    len_if.path_length, want.length));
        if (len_if.length_saturated !== want.sat)
          report_mismatch($sformatf("length_saturated %b, expected %b",
                                    len_if.length_saturated, want.sat));
      end
    end
  end

  // receiver: random stall pattern, free-flowing stretches, and long holds on request
  initial begin : rx_pattern
    int run_len;
    bit run_val;
    int holds_done;
    run_len = 0;
    run_val = 1'b0;
    holds_done = 0;
    len_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_asks > holds_done) begin
        holds_done++;
        len_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        if (run_len == 0) begin
          case ($urandom_range(0, 9))
            0: begin
              run_val = 1'b1;
              run_len = $urandom_range(50, 300);
            end
            1, 2, 3, 4, 5: begin
              run_val = 1'b1;
              run_len = $urandom_range(1, 8);
            end
            default: begin
              run_val = 1'b0;
              run_len = $urandom_range(1, 6);
            end
          endcase
        end
        len_if.ready <= run_val;
        run_len--;
      end
    end
  end

  task automatic push_point(point_t p, bit typed, len_word_t typed_want);
    len_word_t w;
    bit has;
    pt_if.valid <= 1'b1;
    pt_if.coord_x <= p.x;
    pt_if.coord_y <= p.y;
    pt_if.coord_z <= p.z;
    pt_if.point_missing <= p.missing;
    pt_if.last_point <= p.last;
    @(posedge clk_i);
    while (!pt_if.ready) @(posedge clk_i);
    has = advance_path(p, w);
    points_sent++;
    if (p.missing) missing_sent++;
    if (has) pending_lengths.push_back(typed ? typed_want : w);
  endtask

  // sender bursts with random gaps between them
  task automatic pace();
    if (gaps_on) begin
      if (burst_left == 0) begin
        pt_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
  endtask

  // wait for every length word, then let a segment in flight finish
  task automatic drain();
    pt_if.valid <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_dims(bit v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    dims3 = v;
    dims_writes++;
    cfg_we <= 1'b0;
  endtask

  function automatic stim_row_t pt_row(int x, int y, int z, bit miss, bit last,
                                       bit typed = 1'b0, longint want = 0);
    stim_row_t r;
    r.kind = ROW_POINT;
    r.pt.x = COORD_W'(x);
    r.pt.y = COORD_W'(y);
    r.pt.z = COORD_W'(z);
    r.pt.missing = miss;
    r.pt.last = last;
    r.dims = 1'b0;
    r.typed = typed;
    r.want.length = SUM_W'(want);
    r.want.sat = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t dims_row(bit v);
    stim_row_t r;
    r = pt_row(0, 0, 0, 1'b0, 1'b0);
    r.kind = ROW_DIMS;
    r.dims = v;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] corner_coord();
    case ($urandom_range(0, 3))
      0: return COORD_MIN;
      1: return COORD_TOP;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic point_t rand_point(point_t prev, bit last);
    point_t p;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      p.x = prev.x + COORD_W'($urandom_range(0, 4095)) - COORD_W'(2048);
      p.y = prev.y + COORD_W'($urandom_range(0, 4095)) - COORD_W'(2048);
      p.z = prev.z + COORD_W'($urandom_range(0, 4095)) - COORD_W'(2048);
    end else if (kind < 75) begin
      p.x = COORD_W'($urandom);
      p.y = COORD_W'($urandom);
      p.z = COORD_W'($urandom);
    end else if (kind < 88) begin
      p.x = corner_coord();
      p.y = corner_coord();
      p.z = corner_coord();
    end else begin
      p = prev;  // zero-length segment
    end
    p.missing = ($urandom_range(0, 99) < 8);
    p.last = last;
    return p;
  endfunction

  initial begin : stimulus
    stim_row_t rows[$];
    stim_row_t r;
    point_t p, cur;
    int i, ph, k, traj_left;
    bit squeeze;

    pt_if.valid = 1'b0;
    pt_if.coord_x = '0;
    pt_if.coord_y = '0;
    pt_if.coord_z = '0;
    pt_if.point_missing = 1'b0;
    pt_if.last_point = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    last_x = '0;
    last_y = '0;
    last_z = '0;
    last_ok = 1'b0;
    path_sum = '0;
    path_clamped = 1'b0;
    dims3 = 1'b0;
    cur = '0;
    traj_left = 0;

    // starts in 2d after reset
    rows.push_back(pt_row(0, 0, 0, 1'b0, 1'b1, 1'b1, 0));
    rows.push_back(pt_row(0, 0, 0, 1'b0, 1'b0));
    rows.push_back(pt_row(768, 1024, 8388607, 1'b0, 1'b1, 1'b1, 1280));
    rows.push_back(pt_row(100, -100, 7, 1'b1, 1'b1, 1'b1, 0));
    rows.push_back(pt_row(-8388608, -8388608, -8388608, 1'b0, 1'b0));
    rows.push_back(pt_row(8388607, 8388607, 8388607, 1'b0, 1'b1));
    rows.push_back(pt_row(0, 0, 0, 1'b0, 1'b0));
    rows.push_back(pt_row(55, 66, 77, 1'b1, 1'b0));
    rows.push_back(pt_row(256, 0, 0, 1'b0, 1'b0));
    rows.push_back(pt_row(512, 0, 0, 1'b0, 1'b1, 1'b1, 256));
    rows.push_back(pt_row(0, 0, 0, 1'b0, 1'b0));
    rows.push_back(pt_row(1, 1, 0, 1'b0, 1'b0));
    rows.push_back(pt_row(1, 1, 0, 1'b1, 1'b1, 1'b1, 1));
    rows.push_back(pt_row(0, 0, 1280, 1'b0, 1'b0));
    rows.push_back(dims_row(1'b1));
    rows.push_back(pt_row(768, 1024, 1280, 1'b0, 1'b1, 1'b1, 1280));
    rows.push_back(pt_row(0, 0, 0, 1'b0, 1'b0));
    rows.push_back(pt_row(512, 768, 1536, 1'b0, 1'b1, 1'b1, 1792));
    rows.push_back(pt_row(-8388608, -8388608, -8388608, 1'b0, 1'b0));
    rows.push_back(pt_row(8388607, 8388607, 8388607, 1'b0, 1'b1));
    rows.push_back(pt_row(0, 0, 0, 1'b0, 1'b0));
    rows.push_back(dims_row(1'b0));
    rows.push_back(pt_row(768, 1024, -2048, 1'b0, 1'b1, 1'b1, 1280));
    rows.push_back(pt_row(-128, 0, 0, 1'b0, 1'b0));
    rows.push_back(pt_row(128, 0, 0, 1'b0, 1'b1, 1'b1, 256));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < rows.size(); i++) begin
      r = rows[i];
      if (r.kind == ROW_DIMS) begin
        set_dims(r.dims);
      end else begin
        pace();
        push_point(r.pt, r.typed, r.want);
      end
    end

    // one 3d trajectory bouncing between opposite corners, back to back
    set_dims(1'b1);
    gaps_on = 1'b0;
    for (i = 0; i < CORNER_POINTS; i++) begin
      p.x = i[0] ? COORD_TOP : COORD_MIN;
      p.y = p.x;
      p.z = p.x;
      p.missing = 1'b0;
      p.last = (i == CORNER_POINTS - 1);
      push_point(p, 1'b0, '0);
    end

    // random phases; a trajectory may stay open across a mode write
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) set_dims(1'b0);
      else if (ph == 1) set_dims(1'b1);
      else set_dims($urandom_range(0, 1));
      gaps_on = (ph != 4);
      squeeze = (ph == 2);
      if (squeeze) hold_asks++;
      for (k = 0; k < PHASE_POINTS; k++) begin
        if (traj_left == 0) begin
          if (squeeze) traj_left = $urandom_range(1, 2);
          else if ($urandom_range(0, 9) < 2) traj_left = 1;
          else if ($urandom_range(0, 9) < 8) traj_left = $urandom_range(2, 10);
          else traj_left = $urandom_range(11, 60);
        end
        traj_left--;
        p = rand_point(cur, traj_left == 0);
        pace();
        push_point(p, 1'b0, '0);
        if (!p.missing) cur = p;
      end
    end
    if (traj_left != 0) begin
      p = rand_point(cur, 1'b1);
      push_point(p, 1'b0, '0);
    end

    pt_if.valid <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d points (%0d missing), %0d lengths checked, %0d of them saturated",
             points_sent, missing_sent, lengths_checked, sat_seen);
    $display("mode writes: %0d across 2d and 3d, with one long output stall", dims_writes);
    if (mismatches == 0 && pending_lengths.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #100ms;
    $display("timeout with %0d length words outstanding", pending_lengths.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule : testbench
